// ===== hw/rtl/i2rd_pkg.sv =====
// ----------------------------------------------------------------------------
// i2rd_pkg: shared types and constants for integer_to_radix_digits
// Field widths, character codes, register map and controller state encoding.
// ----------------------------------------------------------------------------
package i2rd_pkg;

    // Field and bus widths
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int BASE_W      = 5;
    localparam int DIGIT_W     = 4;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_LSB = 3;

    // Alphabet limits and derived sizes
    localparam int MAX_BASE       = 16;
    localparam int MAX_CHARS      = 33;
    localparam int STACK_DEPTH    = MAX_CHARS - 1;
    localparam int NUM_W          = $clog2(MAX_CHARS);
    localparam int BYTES_PER_WORD = VALUE_W / CHAR_W;
    localparam int BYTE_CNT_W     = $clog2(BYTES_PER_WORD);
    localparam int ALPHA_W        = MAX_BASE * CHAR_W;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CHAR_W-1:0]         char_t;
    typedef logic [DIGIT_W-1:0]        digit_t;

    // Character codes
    localparam char_t CHAR_PLUS  = 8'h2B;
    localparam char_t CHAR_MINUS = 8'h2D;
    localparam char_t CHAR_0     = 8'h30;
    localparam char_t CHAR_9     = 8'h39;
    localparam char_t CHAR_LC_A  = 8'h61;
    localparam char_t CHAR_LC_Z  = 8'h7A;
    localparam char_t CHAR_UC_A  = 8'h41;
    localparam char_t CHAR_UC_Z  = 8'h5A;

    // Register map (index = paddr / 8)
    typedef enum logic [1:0] {
        REG_BASE_SIZE   = 2'd0,
        REG_DIGITS_LOW  = 2'd1,
        REG_DIGITS_HIGH = 2'd2
    } reg_index_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_SIGN   = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

endpackage

// ===== hw/rtl/i2rd_value_if.sv =====
// ----------------------------------------------------------------------------
// i2rd_value_if: input channel carrying one signed integer
// Valid/ready handshake; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface i2rd_value_if import i2rd_pkg::*; ();

    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

// ===== hw/rtl/i2rd_char_if.sv =====
// ----------------------------------------------------------------------------
// i2rd_char_if: output channel carrying one character of a number
// Valid/ready handshake; last marks the final character of each number.
// ----------------------------------------------------------------------------
interface i2rd_char_if import i2rd_pkg::*; ();

    logic  valid;
    logic  ready;
    char_t character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);

endinterface

// ===== hw/rtl/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits: signed integer to text in a configurable radix
// Converts each 32-bit value to its digit characters, most significant first.
//
//   channel    direction  handshake             payload
//   value_in   in         valid/ready           value (signed 32 bits)
//   char_out   out        valid/ready           character (8 bits), last
//   apb        in         psel/penable/pwrite   paddr (5 bits), pwdata/prdata (64)
//
// Each digit comes from a long division by the radix that consumes one byte
// of the magnitude per cycle, with the digits pushed on a stack.
// Characters then leave the stack one per cycle while the output accepts them,
// after a leading '-' for a negative value.
// A value arriving with a rejected alphabet is taken and dropped.
// Output stalls hold the character register and pause the emit phase only.
// Reset clears the configuration registers, which rejects every alphabet.
// ----------------------------------------------------------------------------
module integer_to_radix_digits import i2rd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    i2rd_value_if.sink            value_in,
    i2rd_char_if.source           char_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers
    logic [BASE_W-1:0]     base_size_reg;
    logic [APB_DATA_W-1:0] digits_low_reg;
    logic [APB_DATA_W-1:0] digits_high_reg;

    // Controller and datapath state
    state_t                state_reg, state_next;
    logic [VALUE_W-1:0]    mag_reg, mag_next;
    digit_t                rem_reg, rem_next;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic                  neg_reg, neg_next;
    logic [NUM_W-1:0]      nd_reg, nd_next;
    digit_t                stack_reg [STACK_DEPTH];
    digit_t                stack_next [STACK_DEPTH];
    logic                  out_valid_reg, out_valid_next;
    char_t                 char_reg, char_next;
    logic                  last_reg, last_next;

    logic                  wr_en;
    reg_index_t            reg_index;
    logic [ALPHA_W-1:0]    alphabet;
    logic                  alpha_ok;
    logic                  in_fire;
    logic                  out_free;
    logic [VALUE_W-1:0]    mag_in;
    logic [CHAR_W-1:0]     quo_byte;
    digit_t                rem_step;
    logic [VALUE_W-1:0]    quotient;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1:REG_IDX_LSB]);

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg   <= '0;
            digits_low_reg  <= '0;
            digits_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_BASE_SIZE:   base_size_reg   <= pwdata[BASE_W-1:0];
                REG_DIGITS_LOW:  digits_low_reg  <= pwdata;
                REG_DIGITS_HIGH: digits_high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_index)
            REG_BASE_SIZE:   prdata = APB_DATA_W'(base_size_reg);
            REG_DIGITS_LOW:  prdata = digits_low_reg;
            REG_DIGITS_HIGH: prdata = digits_high_reg;
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Alphabet check: size, leading alphanumeric, no signs, no repeats
    // ------------------------------------------------------------------
    assign alphabet = {digits_high_reg, digits_low_reg};

    always_comb
    begin
        char_t c0;
        char_t ci;
        logic  bad;
        c0  = alphabet[CHAR_W-1:0];
        bad = (base_size_reg < BASE_W'(2)) || (base_size_reg > BASE_W'(MAX_BASE));
        if (!((c0 >= CHAR_0 && c0 <= CHAR_9) || (c0 >= CHAR_LC_A && c0 <= CHAR_LC_Z) ||
              (c0 >= CHAR_UC_A && c0 <= CHAR_UC_Z)))
        begin
            bad = 1'b1;
        end
        for (int i = 0; i < MAX_BASE; i++)
        begin
            ci = alphabet[i*CHAR_W +: CHAR_W];
            if (BASE_W'(i) < base_size_reg)
            begin
                if (ci == CHAR_PLUS || ci == CHAR_MINUS)
                begin
                    bad = 1'b1;
                end
                for (int j = 0; j < i; j++)
                begin
                    if (alphabet[j*CHAR_W +: CHAR_W] == ci)
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
        alpha_ok = !bad;
    end

    // ------------------------------------------------------------------
    // Handshakes and input magnitude
    // ------------------------------------------------------------------
    assign value_in.ready = (state_reg == ST_IDLE);
    assign in_fire        = value_in.valid && (state_reg == ST_IDLE);
    assign out_free       = !out_valid_reg || char_out.ready;
    assign mag_in         = value_in.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value_in.value))
                                                      : VALUE_W'(value_in.value);

    assign char_out.valid     = out_valid_reg;
    assign char_out.character = char_reg;
    assign char_out.last      = last_reg;

    // ------------------------------------------------------------------
    // One byte of long division by the radix: eight restoring steps
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [DIGIT_W:0] part;
        digit_t           rem;
        part     = '0;
        rem      = rem_reg;
        quo_byte = '0;
        for (int i = CHAR_W - 1; i >= 0; i--)
        begin
            part = {rem, mag_reg[VALUE_W-CHAR_W+i]};
            if (part >= base_size_reg)
            begin
                part        = part - base_size_reg;
                quo_byte[i] = 1'b1;
            end
            rem = part[DIGIT_W-1:0];
        end
        rem_step = rem;
    end

    assign quotient = {mag_reg[VALUE_W-CHAR_W-1:0], quo_byte};

    // ------------------------------------------------------------------
    // Controller: divide digit by digit, then emit any sign and the digits
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        byte_cnt_next  = byte_cnt_reg;
        neg_next       = neg_reg;
        nd_next        = nd_reg;
        stack_next     = stack_reg;
        out_valid_next = out_valid_reg && !char_out.ready;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take a value; drop it when the alphabet is rejected
                if (in_fire && alpha_ok)
                begin
                    mag_next      = mag_in;
                    neg_next      = value_in.value[VALUE_W-1];
                    rem_next      = '0;
                    byte_cnt_next = '0;
                    nd_next       = '0;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                // Shift the magnitude one byte, quotient byte enters at the bottom
                mag_next      = quotient;
                rem_next      = rem_step;
                byte_cnt_next = byte_cnt_reg + BYTE_CNT_W'(1);
                if (byte_cnt_reg == BYTE_CNT_W'(BYTES_PER_WORD - 1))
                begin
                    // Push the finished digit and restart the remainder
                    stack_next[0] = rem_step;
                    for (int k = 1; k < STACK_DEPTH; k++)
                    begin
                        stack_next[k] = stack_reg[k-1];
                    end
                    nd_next  = nd_reg + NUM_W'(1);
                    rem_next = '0;
                    if (quotient == '0)
                    begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Pop the most significant digit into the output register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = alphabet[{stack_reg[0], 3'b000} +: CHAR_W];
                    last_next      = (nd_reg == NUM_W'(1));
                    for (int k = 0; k < STACK_DEPTH - 1; k++)
                    begin
                        stack_next[k] = stack_reg[k+1];
                    end
                    nd_next = nd_reg - NUM_W'(1);
                    if (nd_reg == NUM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            byte_cnt_reg  <= '0;
            nd_reg        <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            byte_cnt_reg  <= byte_cnt_next;
            nd_reg        <= nd_next;
            rem_reg       <= rem_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        stack_reg <= stack_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < base_size_reg))
        else $error("division remainder not below radix");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= NUM_W'(STACK_DEPTH))
        else $error("digit stack overflow");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT || state_reg == ST_SIGN) |-> (nd_reg != '0))
        else $error("emit phase with empty digit stack");

    a_reject_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !alpha_ok) |=> (state_reg == ST_IDLE))
        else $error("value with rejected alphabet was not dropped");

endmodule
